[design/bsoc_pkg.sv]
`default_nettype none

package bsoc_pkg;

   // Fixed-point constants, Q2.30 unless noted
   localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
   localparam logic [31:0] LN2_Q30    = 32'd744261118;
   localparam logic [31:0] DECAY_COEF = 32'd1406564236;  // Q0.60
   localparam logic [31:0] HEALTH_K   = 32'd76695050;
   localparam logic [31:0] RES_K      = 32'd122516896;
   localparam logic [31:0] RES_A      = 32'd4509716;
   localparam logic [31:0] RES_B      = 32'd3758096;
   localparam logic [31:0] CAP_DEN    = 32'd12240000;
   localparam logic [33:0] DELTA_CAP  = 34'h2_0000_0000;

   // OCV polynomial in Horner order, Q16.16
   localparam logic signed [31:0] POLY_C [6] = '{
      32'sd1609564, -32'sd4685824, 32'sd5141299,
      -32'sd2654863, 32'sd670433, 32'sd268698
   };

   typedef enum logic [1:0] {
      CSR_SERIES,
      CSR_PARALLEL,
      CSR_STEP,
      CSR_INIT_SOC
   } csr_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD,
      ST_H_MUL, ST_H_DINIT, ST_H_DIV, ST_H_Y,
      ST_X_MUL, ST_X_UPD, ST_X_T1, ST_X_T2, ST_X_T3,
      ST_H_DEC, ST_H_UPD,
      ST_Q_MUL, ST_Q_DINIT, ST_Q_DIV, ST_Q_CAP,
      ST_D_DINIT, ST_D_DIV, ST_D_CAP,
      ST_SOC, ST_P_MUL, ST_P_ADD, ST_V_MUL, ST_V_SAT,
      ST_R_MUL, ST_R_SET, ST_R_MUL2, ST_R_UPD, ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_LOAD,
      OP_H_MUL, OP_H_DINIT, OP_DIV, OP_H_Y,
      OP_X_MUL, OP_X_UPD, OP_X_T1, OP_X_T2, OP_X_T3,
      OP_H_DEC, OP_H_UPD,
      OP_Q_MUL, OP_Q_DINIT, OP_Q_CAP, OP_D_DINIT, OP_D_CAP,
      OP_SOC, OP_P_MUL, OP_P_ADD, OP_V_MUL, OP_V_SAT,
      OP_R_MUL, OP_R_SET, OP_R_MUL2, OP_R_UPD, OP_OUT
   } op_type;

   typedef struct packed {
      logic div_last;
      logic exp_last;
      logic poly_last;
      logic health_reset;
      logic health_zero;
   } status_type;

   // Root 2^(2^-k) in Q1.30 as a chain of floor square roots, k >= 1
   function automatic logic [31:0] exp_root(input int k);
      logic [63:0] c;
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bt;
      c = 64'h8000_0000;
      for (int j = 0; j < k; j++) begin
         v   = c << 30;
         res = '0;
         for (int i = 0; i < 32; i++) begin
            bt = 64'd1 << (62 - 2 * i);
            if (v >= res + bt) begin
               v   = v - (res + bt);
               res = (res >> 1) + bt;
            end else begin
               res = res >> 1;
            end
         end
         c = res;
      end
      return c[31:0];
   endfunction

endpackage

`default_nettype wire

[design/bsoc_req_if.sv]
`default_nettype none

interface bsoc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] current;
   logic signed [31:0] delta_current;
   logic signed [31:0] delta_frequency;
   logic               reset_health;

   modport source (output valid, current, delta_current, delta_frequency, reset_health,
                   input ready);
   modport sink   (input valid, current, delta_current, delta_frequency, reset_health,
                   output ready);
endinterface

`default_nettype wire

[design/bsoc_rsp_if.sv]
`default_nettype none

interface bsoc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] open_voltage;
   logic signed [31:0] resistance;
   logic signed [31:0] charge_state;
   logic        [30:0] health_state;

   modport source (output valid, open_voltage, resistance, charge_state, health_state,
                   input ready);
   modport sink   (input valid, open_voltage, resistance, charge_state, health_state,
                   output ready);
endinterface

`default_nettype wire

[design/bsoc_dp.sv]
`default_nettype none

module bsoc_dp #(
   parameter int EXP_TABLE_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bsoc_pkg::op_type     op,
   output bsoc_pkg::status_type status,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [30:0]          csr_write_data,
   input  logic signed [31:0]   in_current,
   input  logic signed [31:0]   in_delta_current,
   input  logic signed [31:0]   in_delta_frequency,
   input  logic                 in_reset_health,
   output logic signed [31:0]   out_open_voltage,
   output logic signed [31:0]   out_resistance,
   output logic signed [31:0]   out_charge_state,
   output logic [30:0]          out_health_state
);
   import bsoc_pkg::*;

   localparam int KW = $clog2(EXP_TABLE_BITS);
   localparam int RW = 30 - EXP_TABLE_BITS;

   logic [31:0] root_tbl [EXP_TABLE_BITS];

   for (genvar gk = 0; gk < EXP_TABLE_BITS; gk++) begin : g_root
      localparam logic [31:0] RootVal = exp_root(gk + 1);
      assign root_tbl[gk] = RootVal;
   end

   // configuration and persistent state
   logic [7:0]  series_ff, series_in, parallel_ff, parallel_in;
   logic [15:0] step_ff, step_in;
   logic [30:0] init_soc_ff, init_soc_in;
   logic signed [31:0] soc_ff, soc_in;
   logic [30:0] health_ff, health_in;
   logic        loaded_ff, loaded_in;

   // working registers
   logic signed [31:0] cur_ff, cur_in, dcur_ff, dcur_in, dfreq_ff, dfreq_in;
   logic        rh_ff, rh_in;
   logic [31:0] mag_ff, mag_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [31:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [63:0] quo_ff, quo_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [11:0] ni_ff, ni_in;
   logic [29:0] f_ff, f_in;
   logic [31:0] m_ff, m_in;
   logic [KW-1:0] k_ff, k_in;
   logic        eneg_ff, eneg_in;
   logic [33:0] q_ff, q_in, dmag_ff, dmag_in;
   logic signed [31:0] acc_ff, acc_in;
   logic [2:0]  pidx_ff, pidx_in;
   logic signed [31:0] volt_ff, volt_in, res_ff, res_in;
   logic signed [31:0] ov_ff, ov_in, or_ff, or_in, os_ff, os_in;
   logic [30:0] oh_ff, oh_in;

   // combinational helpers
   logic [7:0]  ser_eff, par_eff;
   logic [31:0] den;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic        mul_en;
   logic [32:0] rem_sh;
   logic [4:0]  fbit_idx;
   logic        fbit;
   logic [5:0]  dec_sh;
   logic [63:0] dec_sum, decay;
   logic [31:0] e_val;
   logic signed [35:0] dmag_s, delta_s, soc_sum;
   logic signed [65:0] p_rnd, prod_neg;
   logic [2:0]  pnext;
   logic [33:0] q_cap;

   assign ser_eff  = (series_ff == 8'd0) ? 8'd1 : series_ff;
   assign par_eff  = (parallel_ff == 8'd0) ? 8'd1 : parallel_ff;
   assign den      = CAP_DEN * {24'd0, ser_eff};
   assign mul_p    = mul_a * mul_b;
   assign rem_sh   = {rem_ff, quo_ff[63]};
   assign fbit_idx = 5'(5'd29 - 5'(k_ff));
   assign fbit     = f_ff[fbit_idx];
   assign dec_sh   = 6'(12'd60 - ni_ff);
   assign dec_sum  = prod_ff[63:0] + (64'd1 << (dec_sh - 6'd1));
   assign decay    = dec_sum >> dec_sh;
   assign e_val    = eneg_ff ? 32'((33'(m_ff) + 33'd1) >> 1) : m_ff;
   assign dmag_s   = {2'b00, dmag_ff};
   assign delta_s  = cur_ff[31] ? -dmag_s : dmag_s;
   assign soc_sum  = 36'(soc_ff) - delta_s - 36'(dcur_ff) - 36'(dfreq_ff);
   assign p_rnd    = (prod_ff + 66'sd536870912) >>> 30;
   assign prod_neg = -prod_ff;
   assign pnext    = 3'(pidx_ff + 3'd1);
   assign q_cap    = (quo_ff > 64'(DELTA_CAP)) ? DELTA_CAP : quo_ff[33:0];

   assign status.div_last     = (dcnt_ff == 6'd63);
   assign status.exp_last     = (k_ff == KW'(EXP_TABLE_BITS - 1));
   assign status.poly_last    = (pidx_ff == 3'd4);
   assign status.health_reset = rh_ff;
   assign status.health_zero  = (health_ff == 31'd0);

   // shared multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (op)
         OP_H_MUL: begin
            mul_a = {1'b0, mag_ff};
            mul_b = {1'b0, HEALTH_K};
         end
         OP_X_MUL: begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, root_tbl[k_ff]};
         end
         OP_X_T1: begin
            mul_a = {1'b0, m_ff};
            mul_b = {{(33 - RW){1'b0}}, f_ff[RW-1:0]};
         end
         OP_X_T2: begin
            mul_a = {1'b0, prod_ff[61:30]};
            mul_b = {1'b0, LN2_Q30};
         end
         OP_H_DEC: begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, DECAY_COEF};
         end
         OP_Q_MUL: begin
            mul_a = {1'b0, mag_ff};
            mul_b = {17'd0, step_ff};
         end
         OP_P_MUL: begin
            mul_a = {acc_ff[31], acc_ff};
            mul_b = {soc_ff[31], soc_ff};
         end
         OP_V_MUL: begin
            mul_a = {acc_ff[31], acc_ff};
            mul_b = {25'd0, par_eff};
         end
         OP_R_MUL: begin
            mul_a = {soc_ff[31], soc_ff};
            mul_b = {1'b0, RES_K};
         end
         OP_R_MUL2: begin
            mul_a = {1'b0, e_val};
            mul_b = {1'b0, RES_A};
         end
         default: mul_en = 1'b0;
      endcase
   end

   always_comb begin
      series_in   = series_ff;
      parallel_in = parallel_ff;
      step_in     = step_ff;
      init_soc_in = init_soc_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SERIES:   series_in   = csr_write_data[7:0];
            CSR_PARALLEL: parallel_in = csr_write_data[7:0];
            CSR_STEP:     step_in     = csr_write_data[15:0];
            CSR_INIT_SOC: init_soc_in = csr_write_data;
            default:      series_in   = series_ff;
         endcase
      end
   end

   always_comb begin
      soc_in    = soc_ff;
      health_in = health_ff;
      loaded_in = loaded_ff;
      cur_in    = cur_ff;
      dcur_in   = dcur_ff;
      dfreq_in  = dfreq_ff;
      rh_in     = rh_ff;
      mag_in    = mag_ff;
      prod_in   = mul_en ? mul_p : prod_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      quo_in    = quo_ff;
      dcnt_in   = dcnt_ff;
      ni_in     = ni_ff;
      f_in      = f_ff;
      m_in      = m_ff;
      k_in      = k_ff;
      eneg_in   = eneg_ff;
      q_in      = q_ff;
      dmag_in   = dmag_ff;
      acc_in    = acc_ff;
      pidx_in   = pidx_ff;
      volt_in   = volt_ff;
      res_in    = res_ff;
      ov_in     = ov_ff;
      or_in     = or_ff;
      os_in     = os_ff;
      oh_in     = oh_ff;
      case (op)
         OP_ACCEPT: begin
            cur_in   = in_current;
            dcur_in  = in_delta_current;
            dfreq_in = in_delta_frequency;
            rh_in    = in_reset_health;
         end
         OP_LOAD: begin
            mag_in = cur_ff[31] ? (~cur_ff + 32'd1) : cur_ff;
            if (!loaded_ff) begin
               soc_in    = {1'b0, init_soc_ff};
               loaded_in = 1'b1;
            end
            if (rh_ff) begin
               health_in = ONE_Q30;
            end
         end
         OP_H_DINIT: begin
            quo_in  = prod_ff[63:0];
            dvs_in  = {24'd0, par_eff};
            rem_in  = '0;
            dcnt_in = '0;
         end
         OP_Q_DINIT: begin
            quo_in  = {prod_ff[49:0], 14'd0};
            dvs_in  = den;
            rem_in  = '0;
            dcnt_in = '0;
         end
         OP_D_DINIT: begin
            quo_in  = {q_ff, 30'd0};
            dvs_in  = {1'b0, health_ff};
            rem_in  = '0;
            dcnt_in = '0;
         end
         OP_DIV: begin
            // one restoring step per cycle
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = 32'(rem_sh - {1'b0, dvs_ff});
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh[31:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            dcnt_in = 6'(dcnt_ff + 6'd1);
         end
         OP_H_Y: begin
            ni_in = quo_ff[57:46];
            f_in  = quo_ff[45:16];
            m_in  = {1'b0, ONE_Q30};
            k_in  = '0;
         end
         OP_X_UPD: begin
            if (fbit) begin
               m_in = 32'((prod_ff[63:0] + 64'h2000_0000) >> 30);
            end
            k_in = KW'(k_ff + 1'b1);
         end
         OP_X_T3: m_in = m_ff + prod_ff[61:30];
         OP_H_UPD: begin
            if (ni_ff >= 12'd60 || decay >= 64'(health_ff)) begin
               health_in = '0;
            end else begin
               health_in = health_ff - decay[30:0];
            end
         end
         OP_Q_CAP: begin
            q_in    = q_cap;
            dmag_in = (q_cap != 34'd0) ? DELTA_CAP : 34'd0;
         end
         OP_D_CAP: dmag_in = q_cap;
         OP_SOC: begin
            if (soc_sum > 36'sd2147483647) begin
               soc_in = 32'sh7FFF_FFFF;
            end else if (soc_sum < -36'sd2147483648) begin
               soc_in = 32'sh8000_0000;
            end else begin
               soc_in = soc_sum[31:0];
            end
            acc_in  = POLY_C[0];
            pidx_in = '0;
         end
         OP_P_ADD: begin
            acc_in  = p_rnd[31:0] + POLY_C[pnext];
            pidx_in = pnext;
         end
         OP_V_SAT: begin
            if (prod_ff > 66'sd2147483647) begin
               volt_in = 32'sh7FFF_FFFF;
            end else if (prod_ff < -66'sd2147483648) begin
               volt_in = 32'sh8000_0000;
            end else begin
               volt_in = prod_ff[31:0];
            end
         end
         OP_R_SET: begin
            eneg_in = prod_neg[65];
            f_in    = prod_neg[59:30];
            m_in    = {1'b0, ONE_Q30};
            k_in    = '0;
         end
         OP_R_UPD: res_in = 32'((prod_ff[63:0] + 64'h2000_0000) >> 30) - RES_B;
         OP_OUT: begin
            ov_in = volt_ff;
            or_in = res_ff;
            os_in = soc_ff;
            oh_in = health_ff;
         end
         default: mag_in = mag_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff   <= 8'd1;
         parallel_ff <= 8'd1;
         step_ff     <= 16'd1000;
         init_soc_ff <= ONE_Q30;
         soc_ff      <= '0;
         health_ff   <= ONE_Q30;
         loaded_ff   <= 1'b0;
      end else begin
         series_ff   <= series_in;
         parallel_ff <= parallel_in;
         step_ff     <= step_in;
         init_soc_ff <= init_soc_in;
         soc_ff      <= soc_in;
         health_ff   <= health_in;
         loaded_ff   <= loaded_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      dcur_ff  <= dcur_in;
      dfreq_ff <= dfreq_in;
      rh_ff    <= rh_in;
      mag_ff   <= mag_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
      dcnt_ff  <= dcnt_in;
      ni_ff    <= ni_in;
      f_ff     <= f_in;
      m_ff     <= m_in;
      k_ff     <= k_in;
      eneg_ff  <= eneg_in;
      q_ff     <= q_in;
      dmag_ff  <= dmag_in;
      acc_ff   <= acc_in;
      pidx_ff  <= pidx_in;
      volt_ff  <= volt_in;
      res_ff   <= res_in;
      ov_ff    <= ov_in;
      or_ff    <= or_in;
      os_ff    <= os_in;
      oh_ff    <= oh_in;
   end

   assign out_open_voltage = ov_ff;
   assign out_resistance   = or_ff;
   assign out_charge_state = os_ff;
   assign out_health_state = oh_ff;

endmodule

`default_nettype wire

[design/bsoc_ctrl.sv]
`default_nettype none

module bsoc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bsoc_pkg::status_type status,
   output bsoc_pkg::op_type     op
);
   import bsoc_pkg::*;

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;   // exp caller: 0 health, 1 resistance
   logic      valid_ff, valid_in;
   logic      load_out;

   assign load_out  = (state_ff == ST_OUT) && (!valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_LOAD;
         ST_LOAD:    state_in = status.health_reset ? ST_Q_MUL : ST_H_MUL;
         ST_H_MUL:   state_in = ST_H_DINIT;
         ST_H_DINIT: state_in = ST_H_DIV;
         ST_H_DIV:   if (status.div_last) state_in = ST_H_Y;
         ST_H_Y: begin
            state_in = ST_X_MUL;
            phase_in = 1'b0;
         end
         ST_X_MUL:   state_in = ST_X_UPD;
         ST_X_UPD:   state_in = status.exp_last ? ST_X_T1 : ST_X_MUL;
         ST_X_T1:    state_in = ST_X_T2;
         ST_X_T2:    state_in = ST_X_T3;
         ST_X_T3:    state_in = phase_ff ? ST_R_MUL2 : ST_H_DEC;
         ST_H_DEC:   state_in = ST_H_UPD;
         ST_H_UPD:   state_in = ST_Q_MUL;
         ST_Q_MUL:   state_in = ST_Q_DINIT;
         ST_Q_DINIT: state_in = ST_Q_DIV;
         ST_Q_DIV:   if (status.div_last) state_in = ST_Q_CAP;
         ST_Q_CAP:   state_in = status.health_zero ? ST_SOC : ST_D_DINIT;
         ST_D_DINIT: state_in = ST_D_DIV;
         ST_D_DIV:   if (status.div_last) state_in = ST_D_CAP;
         ST_D_CAP:   state_in = ST_SOC;
         ST_SOC:     state_in = ST_P_MUL;
         ST_P_MUL:   state_in = ST_P_ADD;
         ST_P_ADD:   state_in = status.poly_last ? ST_V_MUL : ST_P_MUL;
         ST_V_MUL:   state_in = ST_V_SAT;
         ST_V_SAT:   state_in = ST_R_MUL;
         ST_R_MUL:   state_in = ST_R_SET;
         ST_R_SET: begin
            state_in = ST_X_MUL;
            phase_in = 1'b1;
         end
         ST_R_MUL2:  state_in = ST_R_UPD;
         ST_R_UPD:   state_in = ST_OUT;
         ST_OUT:     if (load_out) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op = OP_NONE;
      case (state_ff)
         ST_IDLE:    if (req_valid) op = OP_ACCEPT;
         ST_LOAD:    op = OP_LOAD;
         ST_H_MUL:   op = OP_H_MUL;
         ST_H_DINIT: op = OP_H_DINIT;
         ST_H_DIV:   op = OP_DIV;
         ST_H_Y:     op = OP_H_Y;
         ST_X_MUL:   op = OP_X_MUL;
         ST_X_UPD:   op = OP_X_UPD;
         ST_X_T1:    op = OP_X_T1;
         ST_X_T2:    op = OP_X_T2;
         ST_X_T3:    op = OP_X_T3;
         ST_H_DEC:   op = OP_H_DEC;
         ST_H_UPD:   op = OP_H_UPD;
         ST_Q_MUL:   op = OP_Q_MUL;
         ST_Q_DINIT: op = OP_Q_DINIT;
         ST_Q_DIV:   op = OP_DIV;
         ST_Q_CAP:   op = OP_Q_CAP;
         ST_D_DINIT: op = OP_D_DINIT;
         ST_D_DIV:   op = OP_DIV;
         ST_D_CAP:   op = OP_D_CAP;
         ST_SOC:     op = OP_SOC;
         ST_P_MUL:   op = OP_P_MUL;
         ST_P_ADD:   op = OP_P_ADD;
         ST_V_MUL:   op = OP_V_MUL;
         ST_V_SAT:   op = OP_V_SAT;
         ST_R_MUL:   op = OP_R_MUL;
         ST_R_SET:   op = OP_R_SET;
         ST_R_MUL2:  op = OP_R_MUL2;
         ST_R_UPD:   op = OP_R_UPD;
         ST_OUT:     if (load_out) op = OP_OUT;
         default:    op = OP_NONE;
      endcase
   end

   always_comb begin
      if (load_out) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

[design/battery_soc_ocv_model_core.sv]
`default_nettype none

// Channel    Dir   Handshake              Payload
// req_chan   in    valid/ready            current, delta_current, delta_frequency,
//                                          reset_health
// rsp_chan   out   valid/ready            open_voltage, resistance, charge_state,
//                                          health_state
// csr_*      in    write enable only      csr_index, csr_write_data
//
// One item at a time. An item with health decay runs two exp passes and
// three 64-step restoring divides, the divides dominating. With reset_health
// set the health divide and one exp pass are skipped; zero health skips one
// more divide. Reset is synchronous and returns the registers to their
// defaults and health to one. A result waits in the output register while the
// next item is accepted only after that result has been loaded.

module battery_soc_ocv_model_core #(
   parameter int EXP_TABLE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   bsoc_req_if.sink    req_chan,
   bsoc_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_write_data
);
   import bsoc_pkg::*;

   op_type     op;
   status_type status;

   // controller: sequences the shared multiplier, divider and exp steps
   bsoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .op        (op)
   );

   // datapath: holds config, SOC and health, and the output register
   bsoc_dp #(
      .EXP_TABLE_BITS (EXP_TABLE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .op                 (op),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .in_current         (req_chan.current),
      .in_delta_current   (req_chan.delta_current),
      .in_delta_frequency (req_chan.delta_frequency),
      .in_reset_health    (req_chan.reset_health),
      .out_open_voltage   (rsp_chan.open_voltage),
      .out_resistance     (rsp_chan.resistance),
      .out_charge_state   (rsp_chan.charge_state),
      .out_health_state   (rsp_chan.health_state)
   );

   // block stays busy for the item it just took
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input taken again right after an accept");

   // health never exceeds one
   a_health_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.health_state <= ONE_Q30))
      else $error("health above one");

   // a new result only appears while no input is being taken
   a_result_excl: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> !$past(req_chan.ready))
      else $error("result raised from idle");

endmodule

`default_nettype wire
